/* rtl/tsm_pkg.sv */
package tsm_pkg;

   localparam int MaxProcsDefault    = 16;
   localparam int MboxDepthDefault   = 8;
   localparam int PayloadBitsDefault = 32;

   localparam logic [2:0] ACT_SPAWN   = 3'd0;
   localparam logic [2:0] ACT_SEND    = 3'd1;
   localparam logic [2:0] ACT_RECEIVE = 3'd2;
   localparam logic [2:0] ACT_SLICE   = 3'd3;
   localparam logic [2:0] ACT_START   = 3'd4;

   localparam logic [1:0] OUT_TERMINATED = 2'd0;
   localparam logic [1:0] OUT_RETURNED   = 2'd1;
   localparam logic [1:0] OUT_WAITING    = 2'd2;
   localparam logic [1:0] OUT_EXPIRED    = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_SLOT    = 3'd1;
   localparam logic [2:0] ST_BAD_TARGET = 3'd2;
   localparam logic [2:0] ST_MBOX_FULL  = 3'd3;
   localparam logic [2:0] ST_MBOX_EMPTY = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  target_slot;
      logic [31:0] payload;
      logic [1:0]  outcome;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [31:0] payload_out;
      logic        idle;
   } rsp_type;

   // mailbox port command from the scheduler core
   typedef struct packed {
      logic wr;
      logic rd;
   } mbox_cmd_type;

endpackage

/* rtl/tsm_mbox_mem.sv */
module tsm_mbox_mem import tsm_pkg::*; #(
   parameter int Depth = 128,
   parameter int Width = 32
) (
   input  logic                     clock,
   input  mbox_cmd_type             cmd,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[addr] <= wdata;
      end
      if (cmd.rd) begin
         rdata <= mem[addr];
      end
   end

endmodule

/* rtl/thread_scheduler_with_mailboxes.sv */
// Round-robin thread scheduler with per-slot LIFO mailboxes.
//
// Input channel: drive req_data and raise start while busy is low; the
// transaction is taken at that clock edge. Actions are spawn, send,
// receive, slice end and start scheduling.
// Result channel: every request yields one transaction, shown on rsp_data
// for a single cycle with rsp_valid high. The receiver cannot stall it.
// Every action runs through S_EXEC, S_LINK, S_MEM and S_RESP before
// rsp_valid rises; busy stays high meanwhile, so a new request is
// taken only once the last has left S_RESP. The order is set by the
// mailbox memory (one port, registered read): in S_EXEC the event edits
// the flop-based link tables and forms the mailbox address, S_LINK
// issues the access, S_MEM gets the word, and S_RESP registers the result.
// Mailbox payloads live in a synchronous memory of MAX_PROCS*MBOX_DEPTH
// words, indexed slot*MBOX_DEPTH+count; never-written entries are not read.
// Reset (synchronous, active high) clears all slots, lists and counts at
// once; no clearing pass is needed, since the payload memory is read only
// below the per-slot fill count.
module thread_scheduler_with_mailboxes import tsm_pkg::*; #(
   parameter int MAX_PROCS    = MaxProcsDefault,
   parameter int MBOX_DEPTH   = MboxDepthDefault,
   parameter int PAYLOAD_BITS = PayloadBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int PW = $clog2(MAX_PROCS + 1);   // pointer width incl. null
   localparam int SW = $clog2(MAX_PROCS);
   localparam int CW = $clog2(MBOX_DEPTH + 1);
   localparam int MD = MAX_PROCS * MBOX_DEPTH;
   localparam int AW = $clog2(MD);
   localparam logic [PW-1:0] NIL = PW'(MAX_PROCS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_LINK = 3'd2;
   localparam logic [2:0] S_MEM  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   req_type    req_ff;

   logic [MAX_PROCS-1:0] valid_ff, valid_in;
   logic [MAX_PROCS-1:0] asleep_ff, asleep_in;
   logic [PW-1:0] nxt_ff [MAX_PROCS];
   logic [PW-1:0] nxt_in [MAX_PROCS];
   logic [PW-1:0] prv_ff [MAX_PROCS];
   logic [PW-1:0] prv_in [MAX_PROCS];
   logic [CW-1:0] cnt_ff [MAX_PROCS];
   logic [CW-1:0] cnt_in [MAX_PROCS];
   logic [PW-1:0] run_ff, run_in, wait_ff, wait_in, cur_ff, cur_in;

   logic [2:0]    status_ff, status_in;
   logic [3:0]    slot_ff, slot_in;
   logic          pop_ff, pop_in;
   logic          spawn_ff, spawn_in;

   mbox_cmd_type        mcmd;
   logic [AW-1:0]       maddr_ff, maddr_in;
   logic [PAYLOAD_BITS-1:0] mwdata_ff, mrdata;
   logic                mwr_ff, mwr_in, mrd_ff, mrd_in;

   // scratch for the event
   logic [PW-1:0] free_s, tgt, c, succ;
   logic          tgt_ok;

   function automatic logic [AW-1:0] mb_addr(input logic [PW-1:0] s,
                                            input logic [CW-1:0] n);
      logic [AW+PW+CW-1:0] a;
      a = (AW+PW+CW)'(s) * (AW+PW+CW)'(MBOX_DEPTH) + (AW+PW+CW)'(n);
      return a[AW-1:0];
   endfunction

   always_comb begin
      free_s = NIL;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_s = PW'(i);
      end
      tgt    = PW'(req_ff.target_slot);
      tgt_ok = (req_ff.target_slot < 4'(MAX_PROCS > 15 ? 15 : MAX_PROCS))
               || (MAX_PROCS > 15);
      tgt_ok = tgt_ok && (tgt < NIL) && valid_ff[tgt[SW-1:0]];
      c      = cur_ff;
      succ   = (c < NIL) ? nxt_ff[c[SW-1:0]] : NIL;
   end

   // list-edit helpers act on the *_in copies
   always_comb begin
      logic [PW-1:0] p, n, hd;
      logic [SW-1:0] si;
      state_in  = state_ff;
      valid_in  = valid_ff;
      asleep_in = asleep_ff;
      nxt_in    = nxt_ff;
      prv_in    = prv_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      wait_in   = wait_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      pop_in    = pop_ff;
      spawn_in  = spawn_ff;
      maddr_in  = maddr_ff;
      mwr_in    = 1'b0;
      mrd_in    = 1'b0;
      p = NIL; n = NIL; hd = NIL; si = '0;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_EXEC;
         S_EXEC: begin
            status_in = ST_OK;
            pop_in    = 1'b0;
            spawn_in  = 1'b0;
            state_in  = S_LINK;
            case (req_ff.action)
               ACT_SPAWN: begin
                  spawn_in = 1'b1;
                  if (free_s == NIL) begin
                     status_in = ST_NO_SLOT;
                     slot_in   = '0;
                  end else begin
                     si = free_s[SW-1:0];
                     valid_in[si]  = 1'b1;
                     asleep_in[si] = 1'b0;
                     cnt_in[si]    = '0;
                     prv_in[si]    = NIL;
                     nxt_in[si]    = run_ff;
                     if (run_ff < NIL) prv_in[run_ff[SW-1:0]] = free_s;
                     run_in  = free_s;
                     slot_in = 4'(free_s);
                  end
               end
               ACT_SEND: begin
                  if (!tgt_ok) begin
                     status_in = ST_BAD_TARGET;
                  end else if (cnt_ff[tgt[SW-1:0]] >= CW'(MBOX_DEPTH)) begin
                     status_in = ST_MBOX_FULL;
                  end else begin
                     si = tgt[SW-1:0];
                     maddr_in   = mb_addr(tgt, cnt_ff[si]);
                     mwr_in     = 1'b1;
                     cnt_in[si] = cnt_ff[si] + 1'b1;
                     if (asleep_ff[si]) begin
                        // unlink from wait list, push on run head
                        p = prv_ff[si];
                        n = nxt_ff[si];
                        hd = run_ff;
                        if (p < NIL) nxt_in[p[SW-1:0]] = n;
                        else if (tgt == run_ff) hd = n;
                        else if (tgt == wait_ff) wait_in = n;
                        if (n < NIL) prv_in[n[SW-1:0]] = p;
                        prv_in[si] = NIL;
                        nxt_in[si] = hd;
                        if (hd < NIL) prv_in[hd[SW-1:0]] = tgt;
                        run_in = tgt;
                        asleep_in[si] = 1'b0;
                     end
                  end
               end
               ACT_RECEIVE: begin
                  if (c == NIL || cnt_ff[c[SW-1:0]] == '0) begin
                     status_in = ST_MBOX_EMPTY;
                  end else begin
                     si = c[SW-1:0];
                     cnt_in[si] = cnt_ff[si] - 1'b1;
                     maddr_in   = mb_addr(c, cnt_ff[si] - 1'b1);
                     mrd_in     = 1'b1;
                     pop_in     = 1'b1;
                  end
               end
               ACT_SLICE: begin
                  if (c < NIL) begin
                     si = c[SW-1:0];
                     hd = run_ff;
                     if (req_ff.outcome == OUT_TERMINATED ||
                         req_ff.outcome == OUT_RETURNED ||
                         (req_ff.outcome == OUT_WAITING && !asleep_ff[si])) begin
                        p = prv_ff[si];
                        n = nxt_ff[si];
                        if (p < NIL) nxt_in[p[SW-1:0]] = n;
                        else if (c == run_ff) hd = n;
                        else if (c == wait_ff) wait_in = n;
                        if (n < NIL) prv_in[n[SW-1:0]] = p;
                        prv_in[si] = NIL;
                        nxt_in[si] = NIL;
                        run_in = hd;
                        if (req_ff.outcome == OUT_WAITING) begin
                           nxt_in[si] = wait_in;
                           if (wait_in < NIL) prv_in[wait_in[SW-1:0]] = c;
                           wait_in = c;
                           asleep_in[si] = 1'b1;
                        end else begin
                           valid_in[si]  = 1'b0;
                           asleep_in[si] = 1'b0;
                           cnt_in[si]    = '0;
                        end
                     end
                     cur_in = (succ < NIL) ? succ : hd;
                  end
               end
               ACT_START: cur_in = run_ff;
               default: ;
            endcase
         end
         S_LINK: state_in = S_MEM;
         S_MEM:  state_in = S_RESP;
         S_RESP: begin
            if (!spawn_ff) slot_in = (cur_ff < NIL) ? 4'(cur_ff) : 4'd0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         asleep_ff <= '0;
         run_ff    <= NIL;
         wait_ff   <= NIL;
         cur_ff    <= NIL;
         mwr_ff    <= 1'b0;
         mrd_ff    <= 1'b0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < MAX_PROCS; i++) begin
            nxt_ff[i] <= NIL;
            prv_ff[i] <= NIL;
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         asleep_ff <= asleep_in;
         nxt_ff    <= nxt_in;
         prv_ff    <= prv_in;
         cnt_ff    <= cnt_in;
         run_ff    <= run_in;
         wait_ff   <= wait_in;
         cur_ff    <= cur_in;
         mwr_ff    <= mwr_in;
         mrd_ff    <= mrd_in;
         rsp_valid <= (state_ff == S_RESP);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) req_ff <= req_data;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      pop_ff    <= pop_in;
      spawn_ff  <= spawn_in;
      maddr_ff  <= maddr_in;
      mwdata_ff <= req_ff.payload[PAYLOAD_BITS-1:0];
      if (state_ff == S_RESP) begin
         rsp_data.status      <= status_ff;
         rsp_data.slot        <= slot_in;
         rsp_data.payload_out <= pop_ff ? 32'(mrdata) : 32'd0;
         rsp_data.idle        <= (run_ff == NIL) && (cur_ff == NIL);
      end
   end

   // memory command issued in S_LINK from registered address/data
   always_comb begin
      mcmd.wr = mwr_ff && (state_ff == S_LINK);
      mcmd.rd = mrd_ff && (state_ff == S_LINK);
   end

   tsm_mbox_mem #(.Depth(MD), .Width(PAYLOAD_BITS)) u_mbox (
      .clock (clock),
      .cmd   (mcmd),
      .addr  (maddr_ff),
      .wdata (mwdata_ff),
      .rdata (mrdata)
   );

   assign busy = (state_ff != S_IDLE);

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_RESP)
      else $error("response without sequence");
   a_cur_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && cur_ff < NIL) |-> valid_ff[cur_ff[SW-1:0]])
      else $error("current slot not valid");
   a_run_head_awake: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && run_ff < NIL) |-> !asleep_ff[run_ff[SW-1:0]])
      else $error("asleep slot at run head");
   a_no_mem_clash: assert property (@(posedge clock) disable iff (reset)
      !(mcmd.wr && mcmd.rd))
      else $error("mailbox read and write together");

endmodule
